/* rtl/lbvs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lbvs_pkg;

  // Item codes on the mode field.
  localparam logic MODE_LOAD      = 1'b0;
  localparam logic MODE_INFLUENCE = 1'b1;

  localparam int unsigned MAT_ELEMS = 12;
  localparam int unsigned POS_W     = 32;
  localparam int unsigned ELEM_W    = 32;
  localparam int unsigned WEIGHT_W  = 17;
  localparam int unsigned JOINT_W   = 7;
  localparam int unsigned EIDX_W    = 4;

  // Sequencer counter: reads go out on counts 0..NUM_READS-1, the last row
  // reaches its accumulator on count RUN_LAST.
  localparam int unsigned NUM_READS = 12;
  localparam int unsigned RUN_LAST  = 16;
  localparam int unsigned CNT_W     = 5;

  // Column that holds the translation term of a matrix row.
  localparam logic [1:0] COL_TRANS = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic       load;    // latch an influence request
    logic       wr;      // write one matrix element
    logic       rd;      // read one matrix element
    logic [1:0] col;     // column of the element read
    logic [1:0] row;     // row of the element read
    logic       finish;  // round the sums into the output register and clear
  } dp_cmd_t;

endpackage

`default_nettype wire

/* rtl/linear_blend_vertex_skinning.sv */
// Linear blend skinning of vertex positions, Q15.16 positions, Q7.24 matrices.
// Input channel (in_valid_i / in_stall_o) carries two kinds of request. A load
// request (mode 0) writes one element of a joint's 3x4 matrix into the table;
// loads stream at one per cycle while no influence runs. An influence request
// (mode 1) reads the joint's twelve elements through the single table read port,
// one per cycle, through a shared 32x32 multiplier, and adds the weighted
// transformed position into three accumulators; the input stays stalled while
// the influence is in progress. The last influence rounds the sums
// into the output register (out_valid_o / out_stall_i) and clears them. While the
// receiver stalls, the result holds and new requests are still taken; only the
// next closing influence waits until the output register is free.
// Reset clears the accumulators and all handshake state. The matrix table is
// not cleared and must be loaded before any joint is used.
`timescale 1ns / 1ps
`default_nettype none

module linear_blend_vertex_skinning #(
  parameter int MAX_JOINTS = 128
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic                                 mode_i,
  input  wire logic [lbvs_pkg::JOINT_W-1:0]         joint_index_i,
  input  wire logic [lbvs_pkg::EIDX_W-1:0]          element_index_i,
  input  wire logic signed [lbvs_pkg::ELEM_W-1:0]   element_value_i,
  input  wire logic signed [lbvs_pkg::POS_W-1:0]    pos_x_i,
  input  wire logic signed [lbvs_pkg::POS_W-1:0]    pos_y_i,
  input  wire logic signed [lbvs_pkg::POS_W-1:0]    pos_z_i,
  input  wire logic [lbvs_pkg::WEIGHT_W-1:0]        weight_i,
  input  wire logic                                 last_influence_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic signed [lbvs_pkg::POS_W-1:0]         out_x_o,
  output logic signed [lbvs_pkg::POS_W-1:0]         out_y_o,
  output logic signed [lbvs_pkg::POS_W-1:0]         out_z_o,
  output logic                                      saturated_o
);
  import lbvs_pkg::*;

  dp_cmd_t cmd;

  lbvs_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .mode_i           (mode_i),
    .last_influence_i (last_influence_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .cmd_o            (cmd)
  );

  lbvs_dp #(
    .MAX_JOINTS (MAX_JOINTS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .joint_index_i   (joint_index_i),
    .element_index_i (element_index_i),
    .element_value_i (element_value_i),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .pos_z_i         (pos_z_i),
    .weight_i        (weight_i),
    .out_x_o         (out_x_o),
    .out_y_o         (out_y_o),
    .out_z_o         (out_z_o),
    .saturated_o     (saturated_o)
  );

  // An accepted influence keeps the input stalled while its matrix is read.
  a_influence_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (mode_i == MODE_INFLUENCE) |=> in_stall_o)
    else $error("influence request did not start the sequencer");

  // A load completes in its own cycle.
  a_load_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (mode_i == MODE_LOAD) |=> !in_stall_o)
    else $error("load request stalled the input");

  // A new result only follows the closing step of an influence.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result raised outside an influence");

  // Nothing is emitted while the sequencer is still reading the matrix.
  a_no_result_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (mode_i == MODE_INFLUENCE) && !out_valid_o
    |=> !out_valid_o)
    else $error("result raised while an influence was in progress");

endmodule

`default_nettype wire

/* rtl/lbvs_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module lbvs_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              mode_i,
  input  wire logic              last_influence_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output lbvs_pkg::dp_cmd_t      cmd_o
);
  import lbvs_pkg::*;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             last_q, last_d;
  logic             out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (mode_i == MODE_INFLUENCE) begin
            cmd_o.load = 1'b1;
            last_d     = last_influence_i;
            cnt_d      = '0;
            state_d    = ST_RUN;
          end else begin
            cmd_o.wr = 1'b1;
          end
        end
      end
      ST_RUN: begin
        if (cnt_q < CNT_W'(NUM_READS)) begin
          cmd_o.rd  = 1'b1;
          cmd_o.col = cnt_q[1:0];
          cmd_o.row = cnt_q[3:2];
        end
        if (cnt_q == CNT_W'(RUN_LAST)) begin
          state_d = last_q ? ST_FINISH : ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_FINISH: begin
        // The sums may only move into the output register once it is free.
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

/* rtl/lbvs_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module lbvs_dp #(
  parameter int MAX_JOINTS = 128
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire lbvs_pkg::dp_cmd_t                    cmd_i,
  input  wire logic [lbvs_pkg::JOINT_W-1:0]         joint_index_i,
  input  wire logic [lbvs_pkg::EIDX_W-1:0]          element_index_i,
  input  wire logic signed [lbvs_pkg::ELEM_W-1:0]   element_value_i,
  input  wire logic signed [lbvs_pkg::POS_W-1:0]    pos_x_i,
  input  wire logic signed [lbvs_pkg::POS_W-1:0]    pos_y_i,
  input  wire logic signed [lbvs_pkg::POS_W-1:0]    pos_z_i,
  input  wire logic [lbvs_pkg::WEIGHT_W-1:0]        weight_i,
  output logic signed [lbvs_pkg::POS_W-1:0]         out_x_o,
  output logic signed [lbvs_pkg::POS_W-1:0]         out_y_o,
  output logic signed [lbvs_pkg::POS_W-1:0]         out_z_o,
  output logic                                      saturated_o
);
  import lbvs_pkg::*;

  localparam int DEPTH = MAX_JOINTS * MAT_ELEMS;
  localparam int AW    = $clog2(DEPTH);
  localparam int FW    = AW + JOINT_W;

  // Q.32 accumulator rounded half up to Q15.16 and clipped; bit 32 flags a clip.
  function automatic logic [POS_W:0] finish_coord(input logic signed [63:0] acc);
    logic signed [48:0] r;
    logic               hi;
    logic               lo;
    r  = {acc[63], acc[63:16]} + 49'(acc[15]);
    hi = !r[48] && (r[47:31] != '0);
    lo = r[48] && (r[47:31] != '1);
    if (hi) begin
      finish_coord = {1'b1, 1'b0, {(POS_W-1){1'b1}}};
    end else if (lo) begin
      finish_coord = {1'b1, 1'b1, {(POS_W-1){1'b0}}};
    end else begin
      finish_coord = {1'b0, r[POS_W-1:0]};
    end
  endfunction

  logic [ELEM_W-1:0] mem [DEPTH];

  logic [FW-1:0]       joint_ext;
  logic [FW-1:0]       base_full;
  logic [AW-1:0]       wr_addr;
  logic                joint_ok;
  logic                wr_ok;

  logic [AW-1:0]              addr_q;
  logic signed [POS_W-1:0]    px_q, py_q, pz_q;
  logic [WEIGHT_W-1:0]        w_q;
  logic                       zero_q;

  logic                       v1_q;
  logic [1:0]                 col1_q, row1_q;
  logic signed [ELEM_W-1:0]   rdata_q;

  logic signed [ELEM_W-1:0]   m_op;
  logic signed [POS_W-1:0]    p_op;
  logic signed [63:0]         prod_d;
  logic                       v2_q;
  logic [1:0]                 col2_q, row2_q;
  logic signed [63:0]         prod_q;

  logic signed [65:0]         prod_ext;
  logic signed [65:0]         sum_q;
  logic                       v3_q;
  logic [1:0]                 row3_q;
  logic signed [65:0]         tot_q;

  logic signed [65:0]         tot_rnd;
  logic                       v4_q;
  logic [1:0]                 row4_q;
  logic signed [41:0]         t_q;

  logic signed [17:0]         w_s;
  logic signed [59:0]         wp_d;
  logic                       v5_q;
  logic [1:0]                 row5_q;
  logic signed [59:0]         wp_q;

  logic signed [63:0]         acc_q [3];
  logic signed [64:0]         acc_sum;
  logic signed [63:0]         acc_new;

  logic [POS_W:0]             fin_x, fin_y, fin_z;

  assign joint_ext = FW'(joint_index_i);
  assign base_full = (joint_ext << 3) + (joint_ext << 2);
  assign wr_addr   = AW'(base_full + FW'(element_index_i));
  assign joint_ok  = (32'(joint_index_i) < MAX_JOINTS);
  assign wr_ok     = joint_ok && (element_index_i < EIDX_W'(MAT_ELEMS));

  // Matrix table: one write port for loads, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr && wr_ok) begin
      mem[wr_addr] <= element_value_i;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem[addr_q];
    end
  end

  // A joint beyond the table contributes nothing.
  assign m_op = zero_q ? '0 : rdata_q;

  always_comb begin
    unique case (col1_q)
      2'd0:    p_op = px_q;
      2'd1:    p_op = py_q;
      2'd2:    p_op = pz_q;
      default: p_op = POS_W'(32'sd65536);
    endcase
  end

  assign prod_d   = m_op * p_op;
  assign prod_ext = {{2{prod_q[63]}}, prod_q};
  assign tot_rnd  = tot_q + 66'sd8388608;
  assign w_s      = {1'b0, w_q};
  assign wp_d     = t_q * w_s;
  assign acc_sum  = {acc_q[row5_q][63], acc_q[row5_q]} + {{5{wp_q[59]}}, wp_q};

  always_comb begin
    if (acc_sum[64] != acc_sum[63]) begin
      acc_new = acc_sum[64] ? {1'b1, {63{1'b0}}} : {1'b0, {63{1'b1}}};
    end else begin
      acc_new = acc_sum[63:0];
    end
  end

  assign fin_x = finish_coord(acc_q[0]);
  assign fin_y = finish_coord(acc_q[1]);
  assign fin_z = finish_coord(acc_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      v4_q     <= 1'b0;
      v5_q     <= 1'b0;
      acc_q[0] <= '0;
      acc_q[1] <= '0;
      acc_q[2] <= '0;
    end else begin
      v1_q <= cmd_i.rd;
      v2_q <= v1_q;
      v3_q <= v2_q && (col2_q == COL_TRANS);
      v4_q <= v3_q;
      v5_q <= v4_q;
      if (cmd_i.finish) begin
        acc_q[0] <= '0;
        acc_q[1] <= '0;
        acc_q[2] <= '0;
      end else if (v5_q) begin
        acc_q[row5_q] <= acc_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      addr_q <= AW'(base_full);
      px_q   <= pos_x_i;
      py_q   <= pos_y_i;
      pz_q   <= pos_z_i;
      w_q    <= weight_i;
      zero_q <= !joint_ok;
    end else if (cmd_i.rd) begin
      addr_q <= addr_q + 1'b1;
    end
    col1_q <= cmd_i.col;
    row1_q <= cmd_i.row;
    prod_q <= prod_d;
    col2_q <= col1_q;
    row2_q <= row1_q;
    // Columns 0 to 2 build the partial sum; the translation term closes the row.
    if (v2_q) begin
      if (col2_q == 2'd0) begin
        sum_q <= prod_ext;
      end else begin
        sum_q <= sum_q + prod_ext;
      end
    end
    tot_q  <= sum_q + prod_ext;
    row3_q <= row2_q;
    t_q    <= tot_rnd[65:24];
    row4_q <= row3_q;
    wp_q   <= wp_d;
    row5_q <= row4_q;
    if (cmd_i.finish) begin
      out_x_o     <= fin_x[POS_W-1:0];
      out_y_o     <= fin_y[POS_W-1:0];
      out_z_o     <= fin_z[POS_W-1:0];
      saturated_o <= fin_x[POS_W] | fin_y[POS_W] | fin_z[POS_W];
    end
  end

endmodule

`default_nettype wire
